// ===== hw/rtl/mpt_pkg.sv =====
package mpt_pkg;

  // One input transaction as it arrives on the input channel.
  typedef struct packed {
    logic               operation;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic        [7:0]  button_mask;
    logic signed [7:0]  wheel_delta;
    logic               absolute_mode;
  } in_item_t;

  // One result transaction as it leaves on the output channel.
  typedef struct packed {
    logic              status;
    logic        [8:0] pos_x;
    logic        [7:0] pos_y;
    logic        [7:0] buttons;
    logic signed [7:0] wheel;
  } out_item_t;

  // Input operation codes.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_MOUSE = 1'b1;

  // Command codes passed from the front end to the back end.
  typedef logic [1:0] cmd_op_t;
  localparam cmd_op_t CMD_ABS   = 2'd0;
  localparam cmd_op_t CMD_REL   = 2'd1;
  localparam cmd_op_t CMD_QUERY = 2'd2;

  // Classified command held in the queue between the two halves.
  typedef struct packed {
    cmd_op_t            op;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic        [8:0]  abs_x;
    logic        [7:0]  abs_y;
    logic        [7:0]  buttons;
    logic signed [7:0]  wheel_delta;
  } cmd_t;

  localparam int CMD_FIFO_DEPTH = 2;

  // Screen limits and absolute-report offset.
  localparam int X_MAX_INT    = 319;
  localparam int Y_MAX_INT    = 199;
  localparam int ABS_Y_OFFSET = 32;

  // Sensitivity divisor limits and reset value.
  localparam logic [3:0] DIV_MIN   = 4'd1;
  localparam logic [3:0] DIV_MAX   = 4'd8;
  localparam logic [3:0] DIV_RESET = 4'd4;

  // Wheel saturation bounds.
  localparam logic signed [16:0] WHEEL_SUM_MIN = -17'sd32768;
  localparam logic signed [16:0] WHEEL_SUM_MAX = 17'sd32767;
  localparam logic signed [15:0] WHEEL_OUT_MIN = -16'sd128;
  localparam logic signed [15:0] WHEEL_OUT_MAX = 16'sd127;

endpackage

// ===== hw/rtl/mpt_stream_if.sv =====
interface mpt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mpt_front.sv =====
module mpt_front (
  mpt_stream_if.sink       in_ch,
  input  logic             fifo_full,
  output logic             push,
  output mpt_pkg::cmd_t    push_cmd
);
  import mpt_pkg::*;

  in_item_t    item;
  logic        drop;
  logic [14:0] half_x;
  logic [15:0] y_shifted;
  logic [14:0] half_y;

  assign item        = in_ch.payload;
  assign in_ch.ready = !fifo_full;

  // An absolute report with a negative coordinate is consumed and discarded.
  assign drop = (item.operation == OP_REPORT) && item.absolute_mode
                && (item.delta_x[15] || item.delta_y[15]);

  assign push = in_ch.valid && in_ch.ready && !drop;

  // Absolute coordinates: remove the y offset, halve, then clamp to the screen.
  assign half_x    = item.delta_x[15:1];
  assign y_shifted = item.delta_y - 16'(ABS_Y_OFFSET);
  assign half_y    = y_shifted[15:1];

  always_comb begin
    push_cmd             = '0;
    push_cmd.delta_x     = item.delta_x;
    push_cmd.delta_y     = item.delta_y;
    push_cmd.buttons     = item.button_mask;
    push_cmd.wheel_delta = item.wheel_delta;

    if (half_x > 15'(X_MAX_INT)) begin
      push_cmd.abs_x = 9'(X_MAX_INT);
    end else begin
      push_cmd.abs_x = half_x[8:0];
    end

    if (item.delta_y < 16'sd32) begin
      push_cmd.abs_y = '0;
    end else if (half_y > 15'(Y_MAX_INT)) begin
      push_cmd.abs_y = 8'(Y_MAX_INT);
    end else begin
      push_cmd.abs_y = half_y[7:0];
    end

    if (item.operation == OP_QUERY) begin
      push_cmd.op = CMD_QUERY;
    end else if (item.absolute_mode) begin
      push_cmd.op = CMD_ABS;
    end else begin
      push_cmd.op = CMD_REL;
    end
  end

endmodule

// ===== hw/rtl/mpt_cmd_fifo.sv =====
module mpt_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpt_pkg::cmd_t push_data,
  input  logic          pop,
  output mpt_pkg::cmd_t pop_data,
  output logic          full,
  output logic          empty
);
  import mpt_pkg::*;

  localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          entries [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(CMD_FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mpt_divider.sv =====
module mpt_divider #(
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [3:0]    divisor,
  input  logic [QW-1:0] dividend_x,
  input  logic [QW-1:0] dividend_y,
  output logic          done,
  output logic [QW-1:0] quot_x,
  output logic [QW-1:0] quot_y
);
  import mpt_pkg::*;

  // Four quotient bits per cycle for each of the two lanes.
  localparam int DIGITS = (QW + 3) / 4;
  localparam int DW     = DIGITS * 4;
  localparam int CW     = $clog2(DIGITS + 1);

  logic [DW-1:0] num_x;
  logic [DW-1:0] num_y;
  logic [DW-1:0] acc_x;
  logic [DW-1:0] acc_y;
  logic [2:0]    rem_x;
  logic [2:0]    rem_y;
  logic [3:0]    div_q;
  logic [CW-1:0] count;
  logic          busy;
  logic [6:0]    step_x;
  logic [6:0]    step_y;

  // One radix-16 digit: four restoring steps on a narrow remainder.
  function automatic logic [6:0] digit_step(input logic [2:0] rem, input logic [3:0] bits,
                                            input logic [3:0] d);
    logic [3:0] r;
    logic [3:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[2:0], bits[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return {r[2:0], q};
  endfunction

  assign step_x = digit_step(rem_x, num_x[DW-1 -: 4], div_q);
  assign step_y = digit_step(rem_y, num_y[DW-1 -: 4], div_q);

  assign quot_x = acc_x[QW-1:0];
  assign quot_y = acc_y[QW-1:0];

  // Datapath registers load on start and shift one digit per busy cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      num_x <= DW'(dividend_x);
      num_y <= DW'(dividend_y);
      acc_x <= '0;
      acc_y <= '0;
      rem_x <= '0;
      rem_y <= '0;
      div_q <= divisor;
    end else if (busy) begin
      num_x <= num_x << 4;
      num_y <= num_y << 4;
      acc_x <= {acc_x[DW-5:0], step_x[3:0]};
      acc_y <= {acc_y[DW-5:0], step_y[3:0]};
      rem_x <= step_x[6:4];
      rem_y <= step_y[6:4];
    end
  end

  // Digit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DIGITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mpt_back.sv =====
module mpt_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mpt_pkg::cmd_t       cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  logic [3:0]          sensitivity_divisor,
  output logic                div_start,
  output logic [3:0]          div_divisor,
  output logic [FRAC_BITS+15:0] div_dividend_x,
  output logic [FRAC_BITS+15:0] div_dividend_y,
  input  logic                div_done,
  input  logic [FRAC_BITS+15:0] div_quot_x,
  input  logic [FRAC_BITS+15:0] div_quot_y,
  mpt_stream_if.source        out_ch
);
  import mpt_pkg::*;

  localparam int XW = FRAC_BITS + 9;
  localparam int YW = FRAC_BITS + 8;
  localparam int SW = FRAC_BITS + 18;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam logic [SW-1:0] X_LIMIT = SW'(X_MAX_INT) << FRAC_BITS;
  localparam logic [SW-1:0] Y_LIMIT = SW'(Y_MAX_INT) << FRAC_BITS;

  logic               state;
  logic [XW-1:0]      x_fixed;
  logic [YW-1:0]      y_fixed;
  logic [7:0]         held_buttons;
  logic signed [15:0] wheel_sum;
  logic               present;
  logic               sign_x;
  logic               sign_y;
  logic               out_valid;
  out_item_t          out_item;

  logic               can_out;
  logic [15:0]        mag_x;
  logic [15:0]        mag_y;
  logic signed [16:0] wheel_wide;
  logic signed [15:0] wheel_new;
  logic [7:0]         wheel_out;
  logic [SW-1:0]      step_x;
  logic [SW-1:0]      step_y;
  logic [SW-1:0]      sum_x;
  logic [SW-1:0]      sum_y;
  logic [XW-1:0]      x_new;
  logic [YW-1:0]      y_new;

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  // The result register may be reloaded when empty or being taken.
  assign can_out = !out_valid || out_ch.ready;

  assign cmd_pop   = (state == ST_IDLE) && cmd_valid
                     && ((cmd.op != CMD_QUERY) || can_out);
  assign div_start = cmd_pop && (cmd.op == CMD_REL);

  // Divisor clamped to its working range.
  always_comb begin
    if (sensitivity_divisor < DIV_MIN) begin
      div_divisor = DIV_MIN;
    end else if (sensitivity_divisor > DIV_MAX) begin
      div_divisor = DIV_MAX;
    end else begin
      div_divisor = sensitivity_divisor;
    end
  end

  // Magnitudes of the deltas, scaled up into fixed point.
  assign mag_x = cmd.delta_x[15] ? 16'(-cmd.delta_x) : 16'(cmd.delta_x);
  assign mag_y = cmd.delta_y[15] ? 16'(-cmd.delta_y) : 16'(cmd.delta_y);
  assign div_dividend_x = {mag_x, {FRAC_BITS{1'b0}}};
  assign div_dividend_y = {mag_y, {FRAC_BITS{1'b0}}};

  // Saturating wheel accumulation.
  always_comb begin
    wheel_wide = 17'(wheel_sum) + 17'(cmd.wheel_delta);
    if (wheel_wide > WHEEL_SUM_MAX) begin
      wheel_new = WHEEL_SUM_MAX[15:0];
    end else if (wheel_wide < WHEEL_SUM_MIN) begin
      wheel_new = WHEEL_SUM_MIN[15:0];
    end else begin
      wheel_new = wheel_wide[15:0];
    end
  end

  // Wheel reported as a saturated signed byte.
  always_comb begin
    if (wheel_sum > WHEEL_OUT_MAX) begin
      wheel_out = WHEEL_OUT_MAX[7:0];
    end else if (wheel_sum < WHEEL_OUT_MIN) begin
      wheel_out = WHEEL_OUT_MIN[7:0];
    end else begin
      wheel_out = wheel_sum[7:0];
    end
  end

  // Apply the signed quotients and clamp to the screen.
  always_comb begin
    step_x = sign_x ? (SW'(0) - SW'(div_quot_x)) : SW'(div_quot_x);
    step_y = sign_y ? (SW'(0) - SW'(div_quot_y)) : SW'(div_quot_y);
    sum_x  = SW'(x_fixed) + step_x;
    sum_y  = SW'(y_fixed) + step_y;
    if (sum_x[SW-1]) begin
      x_new = '0;
    end else if (sum_x > X_LIMIT) begin
      x_new = X_LIMIT[XW-1:0];
    end else begin
      x_new = sum_x[XW-1:0];
    end
    if (sum_y[SW-1]) begin
      y_new = '0;
    end else if (sum_y > Y_LIMIT) begin
      y_new = Y_LIMIT[YW-1:0];
    end else begin
      y_new = sum_y[YW-1:0];
    end
  end

  // Command execution and tracker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      x_fixed      <= '0;
      y_fixed      <= '0;
      held_buttons <= '0;
      wheel_sum    <= '0;
      present      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !(cmd_pop && (cmd.op == CMD_QUERY))) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op) inside
              CMD_ABS, CMD_REL: begin
                held_buttons <= cmd.buttons;
                present      <= 1'b1;
                wheel_sum    <= wheel_new;
                if (cmd.op == CMD_ABS) begin
                  x_fixed <= {cmd.abs_x, {FRAC_BITS{1'b0}}};
                  y_fixed <= {cmd.abs_y, {FRAC_BITS{1'b0}}};
                end else begin
                  sign_x <= cmd.delta_x[15];
                  sign_y <= cmd.delta_y[15];
                  state  <= ST_DIV;
                end
              end
              CMD_QUERY: begin
                out_valid <= 1'b1;
                if (present) begin
                  out_item.status  <= STATUS_OK;
                  out_item.pos_x   <= x_fixed[XW-1 -: 9];
                  out_item.pos_y   <= y_fixed[YW-1 -: 8];
                  out_item.buttons <= held_buttons;
                  out_item.wheel   <= wheel_out;
                  wheel_sum        <= '0;
                end else begin
                  out_item.status  <= STATUS_NO_MOUSE;
                  out_item.pos_x   <= '0;
                  out_item.pos_y   <= '0;
                  out_item.buttons <= '0;
                  out_item.wheel   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            x_fixed <= x_new;
            y_fixed <= y_new;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mouse_position_tracker_unit.sv =====
// Mouse position tracker. Motion reports and position queries arrive on the
// input channel; each query returns exactly one transaction on the output
// channel, reports return none. The front end accepts one transaction per
// cycle into a two-entry command queue as long as the queue has room, and
// the back end drains it: absolute reports and queries complete directly,
// while a relative report holds the back end, which takes no further command,
// until the shared divider, retiring four quotient bits per cycle for x and
// y together, is done. A query waits in the back end while the previous
// result is still held in the output register. The sensitivity divisor is
// written through cfg_wr_en and cfg_wr_data and should only change while
// the block is idle.
module mouse_position_tracker_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  mpt_stream_if.sink   in_ch,
  mpt_stream_if.source out_ch
);
  import mpt_pkg::*;

  localparam int QW = FRAC_BITS + 16;

  logic          [3:0] sensitivity_divisor;
  logic                fifo_push;
  cmd_t                fifo_push_cmd;
  logic                fifo_pop;
  cmd_t                fifo_head;
  logic                fifo_full;
  logic                fifo_empty;
  logic                div_start;
  logic          [3:0] div_divisor;
  logic       [QW-1:0] div_dividend_x;
  logic       [QW-1:0] div_dividend_y;
  logic                div_done;
  logic       [QW-1:0] div_quot_x;
  logic       [QW-1:0] div_quot_y;

  // Sensitivity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_divisor <= DIV_RESET;
    end else if (cfg_wr_en) begin
      sensitivity_divisor <= cfg_wr_data;
    end
  end

  // Front end: accept and classify transactions.
  mpt_front u_front (
    .in_ch    (in_ch),
    .fifo_full(fifo_full),
    .push     (fifo_push),
    .push_cmd (fifo_push_cmd)
  );

  // Command queue between front and back.
  mpt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fifo_push),
    .push_data(fifo_push_cmd),
    .pop      (fifo_pop),
    .pop_data (fifo_head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // Back end: execute commands and hold the result register.
  mpt_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd                (fifo_head),
    .cmd_valid          (!fifo_empty),
    .cmd_pop            (fifo_pop),
    .sensitivity_divisor(sensitivity_divisor),
    .div_start          (div_start),
    .div_divisor        (div_divisor),
    .div_dividend_x     (div_dividend_x),
    .div_dividend_y     (div_dividend_y),
    .div_done           (div_done),
    .div_quot_x         (div_quot_x),
    .div_quot_y         (div_quot_y),
    .out_ch             (out_ch)
  );

  // Shared two-lane divider for scaled relative motion.
  mpt_divider #(
    .QW(QW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .divisor   (div_divisor),
    .dividend_x(div_dividend_x),
    .dividend_y(div_dividend_y),
    .done      (div_done),
    .quot_x    (div_quot_x),
    .quot_y    (div_quot_y)
  );

  // The queue is never written while full nor read while empty.
  assert property (@(posedge clk) disable iff (rst) !(fifo_push && fifo_full))
    else $error("command queue written while full");

  assert property (@(posedge clk) disable iff (rst) !(fifo_pop && fifo_empty))
    else $error("command queue read while empty");

  // A division never completes in the cycle right after it starts.
  assert property (@(posedge clk) disable iff (rst) div_start |=> !div_done)
    else $error("divider finished too early");

  // A result always lies on the screen.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.payload.pos_x <= 9'(X_MAX_INT)
                      && out_ch.payload.pos_y <= 8'(Y_MAX_INT)))
    else $error("reported position outside the screen");

endmodule

// ===== dv/mouse_position_tracker_unit_tb.sv =====
`timescale 1ns / 1ps

module mouse_position_tracker_unit_tb;
  import mpt_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 180;

  // Tracks the pointer state the same way the block should, and keeps the
  // query responses that are still owed by the block.
  class mouse_tracker_scoreboard;
    logic [3:0] divisor;
    longint     x_pos;
    longint     y_pos;
    logic [7:0] held_buttons;
    longint     wheel_sum;
    bit         present;
    out_item_t  owed_responses[$];
    int         errors;

    function new();
      divisor      = DIV_RESET;
      x_pos        = 0;
      y_pos        = 0;
      held_buttons = '0;
      wheel_sum    = 0;
      present      = 1'b0;
      errors       = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Relative motion in fixed point, divided with truncation toward zero.
    function longint scale_motion(longint d, longint div);
      longint mag;
      longint quot;
      mag  = (d < 0) ? -d : d;
      quot = (mag << FRAC_BITS) / div;
      return (d < 0) ? -quot : quot;
    endfunction

    // Applies one accepted input transaction and records the response it owes.
    function void note_input(in_item_t it);
      longint    dx;
      longint    dy;
      longint    div;
      out_item_t resp;
      dx = $signed(it.delta_x);
      dy = $signed(it.delta_y);
      if (it.operation == OP_REPORT) begin
        if (it.absolute_mode) begin
          // A negative absolute coordinate drops the whole report.
          if (dx < 0 || dy < 0) return;
          x_pos = clamp(dx / 2, 0, X_MAX_INT) << FRAC_BITS;
          y_pos = clamp((dy - ABS_Y_OFFSET) / 2, 0, Y_MAX_INT) << FRAC_BITS;
        end else begin
          div = divisor;
          if (div < DIV_MIN) div = DIV_MIN;
          if (div > DIV_MAX) div = DIV_MAX;
          x_pos = clamp(x_pos + scale_motion(dx, div), 0, longint'(X_MAX_INT) << FRAC_BITS);
          y_pos = clamp(y_pos + scale_motion(dy, div), 0, longint'(Y_MAX_INT) << FRAC_BITS);
        end
        held_buttons = it.button_mask;
        present      = 1'b1;
        wheel_sum    = clamp(wheel_sum + $signed(it.wheel_delta), WHEEL_SUM_MIN, WHEEL_SUM_MAX);
        return;
      end
      resp = '0;
      if (!present) begin
        resp.status = STATUS_NO_MOUSE;
      end else begin
        resp.status  = STATUS_OK;
        resp.pos_x   = 9'(x_pos >> FRAC_BITS);
        resp.pos_y   = 8'(y_pos >> FRAC_BITS);
        resp.buttons = held_buttons;
        resp.wheel   = 8'(clamp(wheel_sum, WHEEL_OUT_MIN, WHEEL_OUT_MAX));
        wheel_sum    = 0;
      end
      owed_responses.push_back(resp);
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compares one output transaction with the oldest owed response.
    task check_result(out_item_t got);
      out_item_t want;
      if (owed_responses.size() == 0) begin
        report("output transaction with no query waiting");
        return;
      end
      want = owed_responses.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.pos_x !== want.pos_x)
        report($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
      if (got.buttons !== want.buttons)
        report($sformatf("buttons got 0x%02h want 0x%02h", got.buttons, want.buttons));
      if (got.wheel !== want.wheel)
        report($sformatf("wheel got %0d want %0d", $signed(got.wheel), $signed(want.wheel)));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;
  bit         no_idle = 1'b0;
  int         ready_hold = 0;
  int         cycle_count = 0;

  mpt_stream_if #(.payload_t(in_item_t))  in_ch ();
  mpt_stream_if #(.payload_t(out_item_t)) out_ch ();

  mouse_tracker_scoreboard sb = new();

  mouse_position_tracker_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Idle length: usually none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic op, int dx, int dy, int btn, int wh, bit absm);
    in_item_t it;
    it.operation     = op;
    it.delta_x       = 16'(dx);
    it.delta_y       = 16'(dy);
    it.button_mask   = 8'(btn);
    it.wheel_delta   = 8'(wh);
    it.absolute_mode = absm;
    return it;
  endfunction

  // Random transaction: mostly reports with a spread of motion sizes.
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it.operation     = ($urandom_range(0, 99) < 30) ? OP_QUERY : OP_REPORT;
    it.button_mask   = 8'($urandom_range(0, 255));
    it.absolute_mode = ($urandom_range(0, 99) < 25);
    if ($urandom_range(0, 1))
      it.wheel_delta = 8'($urandom_range(0, 255));
    else
      it.wheel_delta = 8'(int'($urandom_range(0, 6)) - 3);
    r = $urandom_range(0, 99);
    if (it.absolute_mode && r < 85) begin
      it.delta_x = 16'($urandom_range(0, 700));
      it.delta_y = 16'($urandom_range(0, 480));
    end else if (r < 40) begin
      it.delta_x = 16'(int'($urandom_range(0, 600)) - 300);
      it.delta_y = 16'(int'($urandom_range(0, 600)) - 300);
    end else if (r < 70) begin
      it.delta_x = 16'(int'($urandom_range(0, 10000)) - 5000);
      it.delta_y = 16'(int'($urandom_range(0, 10000)) - 5000);
    end else begin
      it.delta_x = 16'($urandom);
      it.delta_y = 16'($urandom);
    end
    return it;
  endfunction

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic push_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  // Writes the divisor once the block has gone quiet.
  task automatic write_divisor(logic [3:0] value);
    in_ch.valid <= 1'b0;
    while (sb.owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.divisor = value;
  endtask

  // Output side: check each accepted transaction and, unless no_idle is set, stall at random.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ch.ready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mouse_position_tracker_unit test failed");
      $finish;
    end
  end

  initial begin
    in_item_t   directed_q[$];
    logic [3:0] phase_div[7];
    logic signed [7:0] wind_step;
    int         wind_count;

    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset divisor: no-mouse queries, dropped absolute
    // reports, screen-edge clamping, and full-scale relative motion.
    directed_q.push_back(make_item(OP_QUERY, -1, -1, 255, -1, 1'b1));
    directed_q.push_back(make_item(OP_REPORT, -1, 100, 255, 5, 1'b1));
    directed_q.push_back(make_item(OP_REPORT, 100, -32768, 170, 9, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, 32767, -32768, 0, 127, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 0, 0, 0, 127, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 32767, 32767, 255, -128, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, -32768, 32767, 85, -128, 1'b1));
    directed_q.push_back(make_item(OP_REPORT, 1, 33, 1, 0, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 639, 431, 128, 1, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 101, 31, 2, -1, 1'b1));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 32767, 32767, 4, 3, 1'b0));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, -32768, -32768, 8, -3, 1'b0));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 3, 5, 16, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, 1, -3, 32, 0, 1'b0));
    directed_q.push_back(make_item(OP_REPORT, -1, 7, 64, 0, 1'b0));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    directed_q.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
    foreach (directed_q[i]) push_item(directed_q[i]);

    // Random phases, each at its own divisor, the out-of-range codes included.
    phase_div[0] = 4'd1;
    phase_div[1] = 4'd8;
    phase_div[2] = 4'd0;
    phase_div[3] = 4'd15;
    phase_div[4] = 4'd2;
    phase_div[5] = 4'd5;
    phase_div[6] = 4'($urandom_range(0, 15));
    for (int phase = 0; phase < 7; phase++) begin
      write_divisor(phase_div[phase]);
      no_idle = (phase == 1 || phase == 4);
      if (phase == 3) begin
        // Drive the wheel sum into saturation, then walk it back so that the
        // query shows whether the sum stopped at the limit.
        wind_step  = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        wind_count = 260 + $urandom_range(0, 40);
        for (int i = 0; i < wind_count; i++)
          push_item(make_item(OP_REPORT, int'($urandom_range(0, 20)) - 10,
                              int'($urandom_range(0, 20)) - 10,
                              $urandom_range(0, 255), wind_step, 1'b0));
        wind_count = 257 + $urandom_range(0, 3);
        for (int i = 0; i < wind_count; i++)
          push_item(make_item(OP_REPORT, 0, 0, $urandom_range(0, 255),
                              (wind_step > 0) ? -127 : 127, 1'b0));
        push_item(make_item(OP_QUERY, 0, 0, 0, 0, 1'b0));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) push_item(random_item());
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait for the last responses, then give late extras a chance to show.
    while (sb.owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("mouse_position_tracker_unit test passed");
    else
      $display("mouse_position_tracker_unit test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/mpt_pkg.sv
hw/rtl/mpt_stream_if.sv
hw/rtl/mpt_front.sv
hw/rtl/mpt_cmd_fifo.sv
hw/rtl/mpt_divider.sv
hw/rtl/mpt_back.sv
hw/rtl/mouse_position_tracker_unit.sv
dv/mouse_position_tracker_unit_tb.sv
